FILE: rtl/sparse_region_histogram_top_defines.svh
// ----------------------------------------------------------------------------
// sparse region histogram assertion macros
// concurrent assertion helpers for the histogram top
// ----------------------------------------------------------------------------
`ifndef SPARSE_REGION_HISTOGRAM_TOP_DEFINES_SVH
`define SPARSE_REGION_HISTOGRAM_TOP_DEFINES_SVH

// expression holds at every clock edge outside reset
`define SRH_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("srh invariant violated");

// antecedent implies consequent in the same cycle
`define SRH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srh implication violated");

`endif

FILE: rtl/srh_pkg.sv
// ----------------------------------------------------------------------------
// srh_pkg
// shared constants, codes and request types of the sparse region histogram
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srh_pkg;

    localparam int REGION_COUNT = 256;
    localparam int COUNT_BITS   = 32;

    localparam int REGION_W    = 8;
    localparam int AMOUNT_W    = 32;
    localparam int COUNT_OUT_W = 32;
    localparam int SLOT_OUT_W  = 8;
    localparam int ACTIVE_W    = 9;
    localparam int STATUS_W    = 2;

    localparam int IDX_W   = $clog2(REGION_COUNT);
    localparam int TOTAL_W = IDX_W + 1;

    // slot table marker for a region without an entry
    localparam logic [TOTAL_W-1:0] NO_ENTRY = TOTAL_W'(REGION_COUNT);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic {
        CMD_INC = 1'b0,
        CMD_DEC = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED  = 2'd0,
        ST_INSERTED = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_ABSENT   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLOT,
        S_ENTRY,
        S_SHIFT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0]      region;
        logic [COUNT_BITS-1:0] count;
    } t_entry;

    typedef struct packed {
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        logic [TOTAL_W-1:0] wr_data;
    } t_slot_req;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_ent_req;

    typedef struct packed {
        logic [COUNT_BITS-1:0] ins_count;
        logic                  ins_ovf;
        logic [COUNT_BITS-1:0] inc_count;
        logic                  inc_ovf;
        logic                  dec_remove;
        logic [COUNT_BITS-1:0] dec_count;
    } t_alu_out;

endpackage

`default_nettype wire

FILE: rtl/srh_slot_table.sv
// ----------------------------------------------------------------------------
// srh_slot_table
// region to packed-list slot map, one read and one write port, valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srh_slot_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire srh_pkg::t_slot_req            i_req,
    output logic [srh_pkg::TOTAL_W-1:0]        o_rd_slot
);

    logic [srh_pkg::TOTAL_W-1:0] r_mem [srh_pkg::REGION_COUNT];
    logic [srh_pkg::REGION_COUNT-1:0] r_vld;
    logic [srh_pkg::TOTAL_W-1:0] r_rd_data;
    logic r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // written entries only; never-written ones read as no entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_slot = r_rd_vld ? r_rd_data : srh_pkg::NO_ENTRY;

endmodule

`default_nettype wire

FILE: rtl/srh_entry_mem.sv
// ----------------------------------------------------------------------------
// srh_entry_mem
// packed list of (region, count) entries, one read and one write port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srh_entry_mem (
    input  wire logic              i_clk,
    input  wire srh_pkg::t_ent_req i_req,
    output srh_pkg::t_entry        o_rd_data
);

    srh_pkg::t_entry r_mem [srh_pkg::REGION_COUNT];
    srh_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/srh_count_alu.sv
// ----------------------------------------------------------------------------
// srh_count_alu
// saturating add, compare and subtract on one entry count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srh_count_alu (
    input  wire logic [srh_pkg::COUNT_BITS-1:0] i_count,
    input  wire logic [srh_pkg::AMOUNT_W-1:0]   i_amount,
    output srh_pkg::t_alu_out                   o_res
);

    localparam int SUM_W = ((srh_pkg::COUNT_BITS > srh_pkg::AMOUNT_W) ?
                            srh_pkg::COUNT_BITS : srh_pkg::AMOUNT_W) + 1;

    logic [SUM_W-1:0] cnt_ext;
    logic [SUM_W-1:0] amt_ext;
    logic [SUM_W-1:0] cmax_ext;
    logic [SUM_W-1:0] sum;

    always_comb begin
        cnt_ext  = SUM_W'(i_count);
        amt_ext  = SUM_W'(i_amount);
        cmax_ext = SUM_W'(srh_pkg::COUNT_MAX);
        sum      = cnt_ext + amt_ext;

        // new entry takes the amount alone
        o_res.ins_ovf   = amt_ext > cmax_ext;
        o_res.ins_count = o_res.ins_ovf ? srh_pkg::COUNT_MAX
                                        : srh_pkg::COUNT_BITS'(i_amount);
        o_res.inc_ovf   = sum > cmax_ext;
        o_res.inc_count = o_res.inc_ovf ? srh_pkg::COUNT_MAX
                                        : sum[srh_pkg::COUNT_BITS-1:0];
        // amount below count whenever dec_count is used
        o_res.dec_remove = cnt_ext <= amt_ext;
        o_res.dec_count  = i_count - srh_pkg::COUNT_BITS'(i_amount);
    end

endmodule

`default_nettype wire

FILE: rtl/sparse_region_histogram_top.sv
// an insert or absent item passes the slot lookup state, then the finish state; an update also
// passes the entry state; a removal adds a compaction pass over the entries behind the removed slot
// one item at a time: a new item is taken only in the idle state, once the last result has left
// the finish state; compaction moves each later entry down one slot per cycle through the entry
// memory port, and a finished result waits in the finish state while the output stalls
// reset: synchronous active low, slot table valid bits clear at once, no clearing pass
// ----------------------------------------------------------------------------
// sparse_region_histogram_top
// sparse histogram of region counts: slot table plus packed entry list,
// read-modify-write sequencer with in-order compaction on removal
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_region_histogram_top_defines.svh"

module sparse_region_histogram_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input item channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_cmd,
    input  wire logic [srh_pkg::REGION_W-1:0]    i_region,
    input  wire logic [srh_pkg::AMOUNT_W-1:0]    i_amount,
    // result item channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [srh_pkg::COUNT_OUT_W-1:0]      o_count_after,
    output logic [srh_pkg::SLOT_OUT_W-1:0]       o_slot,
    output logic [srh_pkg::ACTIVE_W-1:0]         o_active_entries,
    output logic [srh_pkg::STATUS_W-1:0]         o_status,
    output logic                                 o_overflow
);

    localparam int IDX_W   = srh_pkg::IDX_W;
    localparam int TOTAL_W = srh_pkg::TOTAL_W;

    // sequencer state
    srh_pkg::t_state r_state, n_state;

    // latched item
    srh_pkg::t_cmd              r_cmd, n_cmd;
    logic [srh_pkg::REGION_W-1:0] r_region, n_region;
    logic [srh_pkg::AMOUNT_W-1:0] r_amount, n_amount;

    // list fill and working slot
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [IDX_W-1:0]   r_slot, n_slot;

    // compaction pipeline: read index and the read landing this cycle
    logic [TOTAL_W-1:0] r_rd_idx, n_rd_idx;
    logic               r_pend, n_pend;
    logic [TOTAL_W-1:0] r_pend_idx, n_pend_idx;

    // finished result waiting for the output register
    logic [srh_pkg::COUNT_OUT_W-1:0] r_res_count, n_res_count;
    logic [srh_pkg::SLOT_OUT_W-1:0]  r_res_slot, n_res_slot;
    logic [srh_pkg::ACTIVE_W-1:0]    r_res_active, n_res_active;
    srh_pkg::t_status                r_res_status, n_res_status;
    logic                            r_res_ovf, n_res_ovf;

    // output register
    logic                            r_out_valid, n_out_valid;
    logic [srh_pkg::COUNT_OUT_W-1:0] r_out_count;
    logic [srh_pkg::SLOT_OUT_W-1:0]  r_out_slot;
    logic [srh_pkg::ACTIVE_W-1:0]    r_out_active;
    srh_pkg::t_status                r_out_status;
    logic                            r_out_ovf;

    // memory ports and arithmetic
    srh_pkg::t_slot_req  slot_req;
    logic [TOTAL_W-1:0]  slot_rd;
    srh_pkg::t_ent_req   ent_req;
    srh_pkg::t_entry     ent_rd;
    srh_pkg::t_alu_out   alu;

    // decode of the slot lookup
    logic               in_range;
    logic               present;
    logic               ins_ok;
    logic               shift_rd;
    logic               out_free;
    logic               in_acc;
    logic [IDX_W-1:0]   region_idx;

    srh_slot_table u_slot_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (slot_req),
        .o_rd_slot (slot_rd)
    );

    srh_entry_mem u_entry_mem (
        .i_clk     (i_clk),
        .i_req     (ent_req),
        .o_rd_data (ent_rd)
    );

    srh_count_alu u_count_alu (
        .i_count  (ent_rd.count),
        .i_amount (r_amount),
        .o_res    (alu)
    );

    assign region_idx = IDX_W'(r_region);
    assign in_range   = 32'(r_region) < srh_pkg::REGION_COUNT;
    // slot is only trusted below the fill count
    assign present    = in_range && (slot_rd < r_total);
    // an absent region is appended only for a nonzero amount with room left
    assign ins_ok     = (r_amount != '0) && (32'(r_total) < srh_pkg::REGION_COUNT);
    // compaction keeps reading while later entries remain
    assign shift_rd   = r_rd_idx < r_total;
    assign out_free   = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            srh_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = srh_pkg::S_SLOT;
                end
            end
            srh_pkg::S_SLOT: begin
                n_state = present ? srh_pkg::S_ENTRY : srh_pkg::S_FIN;
            end
            srh_pkg::S_ENTRY: begin
                if (r_cmd == srh_pkg::CMD_DEC && alu.dec_remove) begin
                    n_state = srh_pkg::S_SHIFT;
                end else begin
                    n_state = srh_pkg::S_FIN;
                end
            end
            srh_pkg::S_SHIFT: begin
                if (!shift_rd && !r_pend) begin
                    n_state = srh_pkg::S_FIN;
                end
            end
            srh_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = srh_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = srh_pkg::S_IDLE;
            end
        endcase
    end

    // memory requests and datapath
    always_comb begin
        n_cmd        = r_cmd;
        n_region     = r_region;
        n_amount     = r_amount;
        n_total      = r_total;
        n_slot       = r_slot;
        n_rd_idx     = r_rd_idx;
        n_pend       = 1'b0;
        n_pend_idx   = r_rd_idx;
        n_res_count  = r_res_count;
        n_res_slot   = r_res_slot;
        n_res_active = r_res_active;
        n_res_status = r_res_status;
        n_res_ovf    = r_res_ovf;
        slot_req     = '0;
        ent_req      = '0;
        o_in_ready   = 1'b0;

        case (r_state)
            srh_pkg::S_IDLE: begin
                o_in_ready       = 1'b1;
                n_cmd            = srh_pkg::t_cmd'(i_cmd);
                n_region         = i_region;
                n_amount         = i_amount;
                // look up the slot of the incoming region
                slot_req.rd_en   = in_acc;
                slot_req.rd_addr = IDX_W'(i_region);
            end
            srh_pkg::S_SLOT: begin
                n_slot          = slot_rd[IDX_W-1:0];
                ent_req.rd_en   = present;
                ent_req.rd_addr = slot_rd[IDX_W-1:0];
                n_res_count     = '0;
                n_res_slot      = '0;
                n_res_active    = srh_pkg::ACTIVE_W'(r_total);
                n_res_ovf       = 1'b0;
                n_res_status    = srh_pkg::ST_ABSENT;
                if (in_range && !present && r_cmd == srh_pkg::CMD_INC) begin
                    n_res_status = srh_pkg::ST_UPDATED;
                    if (ins_ok) begin
                        // append at the end of the list
                        ent_req.wr_en          = 1'b1;
                        ent_req.wr_addr        = r_total[IDX_W-1:0];
                        ent_req.wr_data.region = region_idx;
                        ent_req.wr_data.count  = alu.ins_count;
                        slot_req.wr_en         = 1'b1;
                        slot_req.wr_addr       = region_idx;
                        slot_req.wr_data       = r_total;
                        n_total      = r_total + TOTAL_W'(1);
                        n_res_count  = srh_pkg::COUNT_OUT_W'(alu.ins_count);
                        n_res_slot   = srh_pkg::SLOT_OUT_W'(r_total);
                        n_res_active = srh_pkg::ACTIVE_W'(n_total);
                        n_res_status = srh_pkg::ST_INSERTED;
                        n_res_ovf    = alu.ins_ovf;
                    end
                end
            end
            srh_pkg::S_ENTRY: begin
                n_res_slot             = srh_pkg::SLOT_OUT_W'(r_slot);
                n_res_active           = srh_pkg::ACTIVE_W'(r_total);
                n_res_status           = srh_pkg::ST_UPDATED;
                n_res_ovf              = 1'b0;
                ent_req.wr_addr        = r_slot;
                ent_req.wr_data.region = ent_rd.region;
                if (r_cmd == srh_pkg::CMD_INC) begin
                    ent_req.wr_en         = 1'b1;
                    ent_req.wr_data.count = alu.inc_count;
                    n_res_count           = srh_pkg::COUNT_OUT_W'(alu.inc_count);
                    n_res_ovf             = alu.inc_ovf;
                end else if (alu.dec_remove) begin
                    // unmap now, then compact the entries behind this slot
                    slot_req.wr_en   = 1'b1;
                    slot_req.wr_addr = region_idx;
                    slot_req.wr_data = srh_pkg::NO_ENTRY;
                    n_rd_idx         = TOTAL_W'(r_slot) + TOTAL_W'(1);
                    n_res_count      = '0;
                    n_res_status     = srh_pkg::ST_REMOVED;
                end else begin
                    ent_req.wr_en         = 1'b1;
                    ent_req.wr_data.count = alu.dec_count;
                    n_res_count           = srh_pkg::COUNT_OUT_W'(alu.dec_count);
                end
            end
            srh_pkg::S_SHIFT: begin
                // read entry k while entry k-1 read last cycle is written one lower
                ent_req.rd_en   = shift_rd;
                ent_req.rd_addr = r_rd_idx[IDX_W-1:0];
                n_pend          = shift_rd;
                n_pend_idx      = r_rd_idx;
                if (shift_rd) begin
                    n_rd_idx = r_rd_idx + TOTAL_W'(1);
                end
                if (r_pend) begin
                    ent_req.wr_en    = 1'b1;
                    ent_req.wr_addr  = IDX_W'(r_pend_idx - TOTAL_W'(1));
                    ent_req.wr_data  = ent_rd;
                    slot_req.wr_en   = 1'b1;
                    slot_req.wr_addr = ent_rd.region;
                    slot_req.wr_data = r_pend_idx - TOTAL_W'(1);
                end
                if (!shift_rd && !r_pend) begin
                    n_total      = r_total - TOTAL_W'(1);
                    n_res_active = srh_pkg::ACTIVE_W'(n_total);
                end
            end
            srh_pkg::S_FIN: begin
                // result waits here until the output register frees up
            end
            default: begin
            end
        endcase
    end

    assign n_out_valid = (r_state == srh_pkg::S_FIN && out_free) ? 1'b1 :
                         (i_out_ready ? 1'b0 : r_out_valid);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srh_pkg::S_IDLE;
            r_total     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == srh_pkg::S_IDLE) begin
            r_cmd    <= n_cmd;
            r_region <= n_region;
            r_amount <= n_amount;
        end
        r_slot       <= n_slot;
        r_rd_idx     <= n_rd_idx;
        r_pend_idx   <= n_pend_idx;
        r_res_count  <= n_res_count;
        r_res_slot   <= n_res_slot;
        r_res_active <= n_res_active;
        r_res_status <= n_res_status;
        r_res_ovf    <= n_res_ovf;
        if (r_state == srh_pkg::S_FIN && out_free) begin
            r_out_count  <= r_res_count;
            r_out_slot   <= r_res_slot;
            r_out_active <= r_res_active;
            r_out_status <= r_res_status;
            r_out_ovf    <= r_res_ovf;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_count_after    = r_out_count;
    assign o_slot           = r_out_slot;
    assign o_active_entries = r_out_active;
    assign o_status         = r_out_status;
    assign o_overflow       = r_out_ovf;

    // fill count never passes the list depth
    `SRH_ASSERT_ALWAYS(a_total_bound, i_clk, i_rst_n, 32'(r_total) <= srh_pkg::REGION_COUNT)
    // a new result only ever comes out of the finish state
    `SRH_ASSERT_IMPLY(a_out_from_fin, i_clk, i_rst_n, $rose(r_out_valid),
                      $past(r_state == srh_pkg::S_FIN))
    // removed entries report a zero count and no overflow
    `SRH_ASSERT_IMPLY(a_removed_zero, i_clk, i_rst_n,
                      r_out_valid && r_out_status == srh_pkg::ST_REMOVED,
                      r_out_count == '0 && !r_out_ovf)
    // a compaction write always lands below the fill count
    `SRH_ASSERT_IMPLY(a_shift_range, i_clk, i_rst_n, r_state == srh_pkg::S_SHIFT && r_pend,
                      r_pend_idx < r_total && r_pend_idx != '0)

endmodule

`default_nettype wire
